### sv/vpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_pkg
// shared types, codes and reset values for the vpw frame receiver
// ----------------------------------------------------------------------------
package vpw_pkg;

  // default pulse measurement width
  localparam int PULSE_BITS_DEF = 16;

  // widths of the configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // result queue depth, a power of two
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BYTE_WHITEN = 8'h55;

  typedef enum logic [1:0] {
    OP_PULSE = 2'd0,
    OP_EOD   = 2'd1,
    OP_TIMER = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_BUSERR = 2'd2,
    KIND_NOSOF  = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOF_MIN   = 3'd0,
    REG_SHORT_MIN = 3'd1,
    REG_LONG_MAX  = 3'd2,
    REG_MID       = 3'd3,
    REG_MAX_BYTES = 3'd4
  } reg_index_t;

  localparam logic [15:0] SOF_MIN_RST   = 16'd163;
  localparam logic [15:0] SHORT_MIN_RST = 16'd34;
  localparam logic [15:0] LONG_MAX_RST  = 16'd163;
  localparam logic [15:0] MID_RST       = 16'd96;
  localparam logic [7:0]  MAX_BYTES_RST = 8'd12;

  typedef struct packed {
    logic [15:0] sof_min_ticks;
    logic [15:0] short_min_ticks;
    logic [15:0] long_max_ticks;
    logic [15:0] mid_ticks;
    logic [7:0]  max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       last;
  } result_t;

  // up to two results produced by one request
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t make_result(kind_t k, logic [7:0] d, logic [7:0] len,
                                          logic lst);
    result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.frame_length = len;
    r.last         = lst;
    return r;
  endfunction

endpackage

### sv/vpw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw channel interfaces
// bus event request channel and decoded result channel
// ----------------------------------------------------------------------------
interface vpw_event_if #(
  parameter int PULSE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [PULSE_BITS-1:0] pulse_ticks;

  modport source (output valid, output opcode, output pulse_ticks, input ready);
  modport sink   (input valid, input opcode, input pulse_ticks, output ready);
endinterface

interface vpw_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_length;
  logic       last;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  input last, output ready);
endinterface

### sv/vpw_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_decode
// frame state and symbol decode, one request per cycle while go is high
// ----------------------------------------------------------------------------
module vpw_decode import vpw_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  go,
  input  logic [1:0]            opcode,
  input  logic [PULSE_BITS-1:0] pulse_ticks,
  output push_t                 push
);

  localparam int CMP_W = (PULSE_BITS > 16) ? PULSE_BITS : 16;

  logic       in_frame, in_frame_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] byte_count, byte_count_next;

  logic [CMP_W-1:0] p, sof, smin, lmax, mid;
  logic             bit_one, in_range;
  logic [7:0]       sb_shift, bc_inc;

  always_comb begin
    p        = CMP_W'(pulse_ticks);
    sof      = CMP_W'(cfg.sof_min_ticks);
    smin     = CMP_W'(cfg.short_min_ticks);
    lmax     = CMP_W'(cfg.long_max_ticks);
    mid      = CMP_W'(cfg.mid_ticks);
    bit_one  = p > mid;
    in_range = (p >= smin) && (p <= lmax);
    sb_shift = {shift_byte[6:0], bit_one};
    bc_inc   = byte_count + 8'd1;

    in_frame_next   = in_frame;
    shift_byte_next = shift_byte;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    push            = '0;

    if (go) begin
      if (!in_frame) begin
        case (opcode)
          OP_PULSE: begin
            if (p >= sof) begin
              if (cfg.max_frame_bytes == 8'd0) begin
                // zero byte limit: frame closes on its start pulse
                push.count = 2'd1;
                push.r0    = make_result(KIND_OK, 8'd0, 8'd0, 1'b1);
              end else begin
                in_frame_next = 1'b1;
              end
            end
          end
          OP_TIMER: begin
            push.count = 2'd1;
            push.r0    = make_result(KIND_NOSOF, 8'd0, 8'd0, 1'b1);
          end
          default: ;
        endcase
      end else begin
        case (opcode)
          OP_PULSE: begin
            if (!in_range) begin
              push.count      = 2'd1;
              push.r0         = make_result(KIND_BUSERR, 8'd0, 8'd0, 1'b1);
              in_frame_next   = 1'b0;
              shift_byte_next = 8'd0;
              bit_count_next  = 3'd0;
              byte_count_next = 8'd0;
            end else if (bit_count == 3'd7) begin
              shift_byte_next = 8'd0;
              bit_count_next  = 3'd0;
              if (bc_inc == cfg.max_frame_bytes) begin
                push.count      = 2'd2;
                push.r0         = make_result(KIND_DATA, sb_shift ^ BYTE_WHITEN, 8'd0, 1'b0);
                push.r1         = make_result(KIND_OK, 8'd0, bc_inc, 1'b1);
                in_frame_next   = 1'b0;
                byte_count_next = 8'd0;
              end else begin
                push.count      = 2'd1;
                push.r0         = make_result(KIND_DATA, sb_shift ^ BYTE_WHITEN, 8'd0, 1'b1);
                byte_count_next = bc_inc;
              end
            end else begin
              shift_byte_next = sb_shift;
              bit_count_next  = bit_count + 3'd1;
            end
          end
          OP_EOD: begin
            // partial byte dropped
            push.count      = 2'd1;
            push.r0         = make_result(KIND_OK, 8'd0, byte_count, 1'b1);
            in_frame_next   = 1'b0;
            shift_byte_next = 8'd0;
            bit_count_next  = 3'd0;
            byte_count_next = 8'd0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      shift_byte <= 8'd0;
      bit_count  <= 3'd0;
      byte_count <= 8'd0;
    end else begin
      in_frame   <= in_frame_next;
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // idle means all frame counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (bit_count == 3'd0 && byte_count == 8'd0 && shift_byte == 8'd0))
    else $error("frame state not cleared while idle");

  // a two-result request always closes the frame
  a_pair_closes: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |=> !in_frame)
    else $error("frame still open after byte limit");
`endif

endmodule

### sv/vpw_res_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_res_queue
// small result queue, up to two writes and one read a cycle
// ----------------------------------------------------------------------------
module vpw_res_queue import vpw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  push_t               push,
  output logic                room,
  vpw_result_if.source        results
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;
  result_t            head;

  assign room = count <= CNT_W'(QUEUE_DEPTH - 2);
  assign pop  = results.valid && results.ready;
  assign head = mem[rd_ptr];

  assign results.valid        = count != '0;
  assign results.kind         = head.kind;
  assign results.data_byte    = head.data_byte;
  assign results.frame_length = head.frame_length;
  assign results.last         = head.last;

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

### sv/vpw_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_frame_receiver
// variable-pulse-width bus receiver: measured pulses and timer events in,
// whitened data bytes and frame status out
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  events    in   valid/ready   opcode, pulse_ticks
//  results   out  valid/ready   kind, data_byte, frame_length, last
//  cfg       in   cfg_we        cfg_index, cfg_data (write only)
//
//  one request accepted per cycle while the queue has room for two results;
//  results leave one per cycle while results.ready is high, so a frame closed on
//  its byte limit puts two results in the queue; a request passes the request
//  register, then decode into the result queue, whose head drives results
//  reset (rst, synchronous) idles the frame, empties the queue and loads the
//  default thresholds
//  a stall on results backs up through the queue, then the request register
// ----------------------------------------------------------------------------
module vpw_frame_receiver import vpw_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  vpw_event_if.sink              events,
  vpw_result_if.source           results
);

  cfg_t cfg;

  // request register
  logic                  ev_valid;
  logic [1:0]            ev_opcode;
  logic [PULSE_BITS-1:0] ev_pulse;

  logic  room;
  logic  go;
  push_t push;

  // the held request is decoded once the queue can take two results
  assign go           = ev_valid && room;
  assign events.ready = !ev_valid || room;

  // configuration registers, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sof_min_ticks   <= SOF_MIN_RST;
      cfg.short_min_ticks <= SHORT_MIN_RST;
      cfg.long_max_ticks  <= LONG_MAX_RST;
      cfg.mid_ticks       <= MID_RST;
      cfg.max_frame_bytes <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOF_MIN:   cfg.sof_min_ticks   <= cfg_data;
        REG_SHORT_MIN: cfg.short_min_ticks <= cfg_data;
        REG_LONG_MAX:  cfg.long_max_ticks  <= cfg_data;
        REG_MID:       cfg.mid_ticks       <= cfg_data;
        REG_MAX_BYTES: cfg.max_frame_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // request valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (events.ready) begin
      ev_valid <= events.valid;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev_opcode <= events.opcode;
      ev_pulse  <= events.pulse_ticks;
    end
  end

  vpw_decode #(
    .PULSE_BITS (PULSE_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .go          (go),
    .opcode      (ev_opcode),
    .pulse_ticks (ev_pulse),
    .push        (push)
  );

  vpw_res_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

`ifndef NO_ASSERTIONS
  // a held request is never dropped while it waits for queue room
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !room |=> ev_valid && $stable(ev_opcode) && $stable(ev_pulse))
    else $error("waiting request lost");
`endif

endmodule
